// ===== design/url_tok_pkg.sv =====
// url_tok_pkg: shared constants and types for the url byte tokenizer
// depends on nothing; imported by url_byte_tokenizer
`default_nettype none
package url_tok_pkg;

   localparam int MAX_PAIRS = 16;
   localparam int PAIR_W    = $clog2(MAX_PAIRS + 1);

   localparam int CH_W     = 8;
   localparam int TAG_W    = 3;
   localparam int IDX_W    = 4;
   localparam int STATUS_W = 3;
   localparam int PORT_W   = 16;
   localparam int ACC_W    = 17;
   localparam int COUNT_W  = 5;

   localparam int RSP_DATA_BITS = CH_W + IDX_W + STATUS_W + PORT_W + 1 + COUNT_W;
   localparam int RSP_DATA_W    = ((RSP_DATA_BITS + 7) / 8) * 8;

   localparam logic [ACC_W-1:0]   PORT_SAT  = ACC_W'(65536);
   localparam logic [ACC_W-1:0]   PORT_MAX  = ACC_W'(65535);
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [CH_W-1:0] CH_COLON = 8'h3A;
   localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
   localparam logic [CH_W-1:0] CH_HASH  = 8'h23;
   localparam logic [CH_W-1:0] CH_QUEST = 8'h3F;
   localparam logic [CH_W-1:0] CH_AMP   = 8'h26;
   localparam logic [CH_W-1:0] CH_EQ    = 8'h3D;
   localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
   localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CH_W-1:0] CH_UP_A  = 8'h41;
   localparam logic [CH_W-1:0] CH_UP_Z  = 8'h5A;
   localparam logic [CH_W-1:0] CH_LO_A  = 8'h61;
   localparam logic [CH_W-1:0] CH_LO_Z  = 8'h7A;
   localparam logic [CH_W-1:0] CASE_BIT = 8'h20;

   typedef enum logic [TAG_W-1:0] {
      TAG_SCHEME  = 3'd0,
      TAG_DELIM   = 3'd1,
      TAG_HOST    = 3'd2,
      TAG_PORT    = 3'd3,
      TAG_PATH    = 3'd4,
      TAG_QNAME   = 3'd5,
      TAG_QVALUE  = 3'd6,
      TAG_IGNORED = 3'd7
   } tag_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_NO_COLON   = 3'd1,
      ST_BAD_SCHEME = 3'd2,
      ST_NO_SLASHES = 3'd3,
      ST_UNEXP_END  = 3'd4
   } status_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  pair_count;
      logic                port_ok;
      logic [PORT_W-1:0]   port_value;
      logic                done_res;
      status_type          status;
      logic [IDX_W-1:0]    pair_index;
      tag_type             tag;
      logic [CH_W-1:0]     char_out;
   } rsp_type;

endpackage
`default_nettype wire

// ===== design/url_byte_tokenizer.sv =====
// url_byte_tokenizer: streaming url tokenizer, one byte in and one tagged result out
// depends on url_tok_pkg
// throughput: one request per cycle while the skid entry is empty
// each request updates the parse state and is registered into the result stage
// a two-entry result stage keeps requests flowing while a result waits
// reset (synchronous, active high) returns to the scheme phase with clear counters
// the end-of-url request also clears the parse state for the next url
`default_nettype none
module url_byte_tokenizer (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   input  wire logic [7:0]                          req_tdata,  // ch
   input  wire logic                                req_tlast,  // end_of_url
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // char_out, pair_index, status, port_value, port_ok, pair_count, zero fill
   output      logic [url_tok_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output      logic [url_tok_pkg::TAG_W-1:0]       rsp_tuser,  // tag
   output      logic                                rsp_tlast   // done_res
);
   import url_tok_pkg::*;

   typedef enum logic [3:0] {
      PH_SCHEME, PH_SLASH1, PH_SLASH2, PH_HOST, PH_PORT,
      PH_PATH, PH_QNAME, PH_QVALUE, PH_SKIP, PH_ERROR
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic               scheme_bad_ff, scheme_bad_in;
   logic [ACC_W-1:0]   port_accum_ff, port_accum_in;
   logic               port_closed_ff, port_closed_in;
   logic [PAIR_W-1:0]  pairs_ff, pairs_in;
   logic               name_first_ff, name_first_in;
   status_type         error_ff, error_in;

   rsp_type            main_ff, main_in, skid_ff, skid_in, result;
   logic               main_valid_ff, main_valid_in, skid_valid_ff, skid_valid_in;

   logic [CH_W-1:0]         c;
   logic                    accept, pop;
   logic [PAIR_W+COUNT_W-1:0] pairs_wide, idx_wide;
   logic [19:0]             port_next;
   status_type              end_status;

   assign c      = req_tdata;
   assign accept = req_tvalid && req_tready;
   assign pop    = rsp_tvalid && rsp_tready;

   always_comb begin
      phase_in       = phase_ff;
      scheme_bad_in  = scheme_bad_ff;
      port_accum_in  = port_accum_ff;
      port_closed_in = port_closed_ff;
      pairs_in       = pairs_ff;
      name_first_in  = name_first_ff;
      error_in       = error_ff;
      idx_wide       = '0;
      port_next      = 20'(port_accum_ff) * 20'd10 + 20'(c - CH_ZERO);
      end_status     = error_ff;

      result            = '0;
      result.char_out   = c;
      result.tag        = TAG_IGNORED;

      if (req_tlast) begin
         if (error_ff == ST_OK) begin
            case (phase_ff)
               PH_SCHEME:                end_status = ST_NO_COLON;
               PH_SLASH1, PH_SLASH2:     end_status = ST_NO_SLASHES;
               PH_HOST, PH_PORT:         end_status = ST_UNEXP_END;
               default:                  end_status = ST_OK;
            endcase
         end
         result.char_out = '0;
         result.status   = end_status;
         result.done_res = 1'b1;
         if (end_status == ST_OK && port_accum_ff != '0 && port_accum_ff <= PORT_MAX) begin
            result.port_ok    = 1'b1;
            result.port_value = port_accum_ff[PORT_W-1:0];
         end
         phase_in       = PH_SCHEME;
         scheme_bad_in  = 1'b0;
         port_accum_in  = '0;
         port_closed_in = 1'b0;
         pairs_in       = '0;
         name_first_in  = 1'b1;
         error_in       = ST_OK;
      end else begin
         case (phase_ff)
            PH_SCHEME: begin
               if (c == CH_COLON) begin
                  result.tag = TAG_DELIM;
                  if (scheme_bad_ff) begin
                     error_in = ST_BAD_SCHEME;
                     phase_in = PH_ERROR;
                  end else begin
                     phase_in = PH_SLASH1;
                  end
               end else begin
                  result.tag = TAG_SCHEME;
                  if (!(c inside {[CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z],
                                  CH_PLUS, CH_MINUS, CH_DOT}))
                     scheme_bad_in = 1'b1;
                  if (c inside {[CH_UP_A:CH_UP_Z]})
                     result.char_out = c | CASE_BIT;
               end
            end
            PH_SLASH1, PH_SLASH2: begin
               if (c == CH_SLASH) begin
                  result.tag = TAG_DELIM;
                  phase_in   = (phase_ff == PH_SLASH1) ? PH_SLASH2 : PH_HOST;
               end else begin
                  error_in = ST_NO_SLASHES;
                  phase_in = PH_ERROR;
               end
            end
            PH_HOST: begin
               if (c == CH_COLON) begin
                  result.tag = TAG_DELIM;
                  phase_in   = PH_PORT;
               end else if (c == CH_SLASH) begin
                  result.tag = TAG_DELIM;
                  phase_in   = PH_PATH;
               end else begin
                  result.tag = TAG_HOST;
               end
            end
            PH_PORT: begin
               if (c == CH_SLASH) begin
                  result.tag = TAG_DELIM;
                  phase_in   = PH_PATH;
               end else begin
                  result.tag = TAG_PORT;
                  if (!port_closed_ff && c inside {[CH_ZERO:CH_NINE]})
                     port_accum_in = (port_next > 20'(PORT_SAT)) ? PORT_SAT
                                                                 : port_next[ACC_W-1:0];
                  else
                     port_closed_in = 1'b1;
               end
            end
            PH_PATH: begin
               if (c == CH_HASH) begin
                  result.tag = TAG_DELIM;
                  phase_in   = PH_SKIP;
               end else if (c == CH_QUEST) begin
                  result.tag    = TAG_DELIM;
                  phase_in      = PH_QNAME;
                  name_first_in = 1'b1;
               end else begin
                  result.tag = TAG_PATH;
               end
            end
            PH_QNAME: begin
               if (!name_first_ff && c == CH_EQ) begin
                  result.tag = TAG_DELIM;
                  pairs_in   = pairs_ff + 1'b1;
                  phase_in   = PH_QVALUE;
               end else begin
                  result.tag    = TAG_QNAME;
                  idx_wide      = (PAIR_W+COUNT_W)'(pairs_ff);
                  name_first_in = 1'b0;
               end
            end
            PH_QVALUE: begin
               if (c == CH_AMP) begin
                  if (pairs_ff >= PAIR_W'(MAX_PAIRS)) begin
                     result.tag = TAG_IGNORED;
                     phase_in   = PH_SKIP;
                  end else begin
                     result.tag    = TAG_DELIM;
                     phase_in      = PH_QNAME;
                     name_first_in = 1'b1;
                  end
               end else begin
                  result.tag = TAG_QVALUE;
                  idx_wide   = (PAIR_W+COUNT_W)'(pairs_ff - 1'b1);
               end
            end
            default: result.tag = TAG_IGNORED;
         endcase
         result.status = error_in;
      end

      pairs_wide        = (PAIR_W+COUNT_W)'(req_tlast ? pairs_ff : pairs_in);
      result.pair_index = idx_wide[IDX_W-1:0];
      result.pair_count = (pairs_wide > (PAIR_W+COUNT_W)'(COUNT_MAX)) ? COUNT_MAX
                                                                      : pairs_wide[COUNT_W-1:0];
   end

   // result stage with skid entry
   always_comb begin
      main_in       = main_ff;
      main_valid_in = main_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            main_in       = result;
            main_valid_in = 1'b1;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (accept) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
      if (reset) begin
         phase_ff       <= PH_SCHEME;
         scheme_bad_ff  <= 1'b0;
         port_accum_ff  <= '0;
         port_closed_ff <= 1'b0;
         pairs_ff       <= '0;
         name_first_ff  <= 1'b1;
         error_ff       <= ST_OK;
         main_valid_ff  <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff       <= phase_in;
            scheme_bad_ff  <= scheme_bad_in;
            port_accum_ff  <= port_accum_in;
            port_closed_ff <= port_closed_in;
            pairs_ff       <= pairs_in;
            name_first_ff  <= name_first_in;
            error_ff       <= error_in;
         end
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   assign req_tready = !skid_valid_ff;
   assign rsp_tvalid = main_valid_ff;
   assign rsp_tuser  = main_ff.tag;
   assign rsp_tlast  = main_ff.done_res;
   assign rsp_tdata  = RSP_DATA_W'({main_ff.pair_count, main_ff.port_ok, main_ff.port_value,
                                    main_ff.status, main_ff.pair_index, main_ff.char_out});

endmodule
`default_nettype wire
